/* hdl/cfe_pkg.sv */
// Shared types and constants for the cylinder field evaluator.
// Used by cylinder_field_eval and its port checker; depends on nothing.

package cfe_pkg;

  // Register index codes on the configuration port.
  typedef enum logic [2:0] {
    REG_AXIS_X      = 3'd0,
    REG_AXIS_Y      = 3'd1,
    REG_AXIS_Z      = 3'd2,
    REG_RADIUS      = 3'd3,
    REG_FULL_LENGTH = 3'd4
  } cfg_idx_t;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;

  localparam int POINT_W = 16;   // Q8.8 point components
  localparam int AXIS_W = 16;    // Q2.14 axis components
  localparam int RADIUS_W = 15;  // Q7.8 unsigned radius
  localparam int LEN_W = 17;     // Q9.8 signed cylinder length
  localparam int FIELD_W = 18;   // Q10.8 signed field value
  localparam int AXIS_FRAC = 14;

  // Internal widths, sized for any register bit pattern.
  localparam int PROD_W = POINT_W + AXIS_W;           // p * n
  localparam int DOT_W = PROD_W + 1;                  // sum of three products
  localparam int PROJ_W = DOT_W - AXIS_FRAC;          // d, Q11.8
  localparam int PROJ2_W = PROJ_W + AXIS_W;           // d * n
  localparam int SHIFT_W = PROJ2_W - AXIS_FRAC;       // floor(d * n / 2^14)
  localparam int PERP_W = SHIFT_W + 1;                // p - shifted projection
  localparam int SQ_W = 2 * PERP_W;                   // squared length, Q28.16
  localparam int ROOT_W = SQ_W / 2;                   // root bits, one per stage
  localparam int REM_W = ROOT_W + 2;
  localparam int FWIDE_W = ROOT_W + 2;

  localparam logic signed [AXIS_W-1:0] AXIS_X_RST = 16'sd0;
  localparam logic signed [AXIS_W-1:0] AXIS_Y_RST = 16'sd0;
  localparam logic signed [AXIS_W-1:0] AXIS_Z_RST = 16'sd16384;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 15'd256;
  localparam logic signed [LEN_W-1:0] LEN_RST = -17'sd1;

  localparam logic signed [FIELD_W-1:0] FIELD_MIN = -18'sd131072;
  localparam logic signed [FIELD_W-1:0] CAP_VALUE = -18'sd256;

endpackage

/* hdl/cylinder_field_eval.sv */
// Cylinder implicit field evaluator: a fixed-point pipeline from point to field value.
// Depends on cfe_pkg for widths, register codes and constants.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_stall    in_point_x, in_point_y, in_point_z
//   out      output     out_valid / out_stall  out_field_value
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One point enters per cycle while the input does not stall; each result passes through
// six arithmetic stages, one stage per bit of the 22-bit square root, one output stage.
// Every stage holds its own valid bit and loads whenever it is empty or its successor
// loads, so bubbles close up behind a stalled result and the input stalls only when
// every stage is full.
// Reset is synchronous; it empties the pipeline and restores the register defaults.
// cfg_ready is always high.

module cylinder_field_eval (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [cfe_pkg::POINT_W-1:0]      in_point_x,
  input  logic signed [cfe_pkg::POINT_W-1:0]      in_point_y,
  input  logic signed [cfe_pkg::POINT_W-1:0]      in_point_z,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [cfe_pkg::FIELD_W-1:0]      out_field_value,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [cfe_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [cfe_pkg::CFG_DATA_W-1:0]          cfg_data
);

  localparam int NSQ = cfe_pkg::ROOT_W;

  // Configuration registers.
  logic signed [cfe_pkg::AXIS_W-1:0]   axis_r [0:2];
  logic [cfe_pkg::RADIUS_W-1:0]        radius_r;
  logic signed [cfe_pkg::LEN_W-1:0]    full_length_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r[0]     <= cfe_pkg::AXIS_X_RST;
      axis_r[1]     <= cfe_pkg::AXIS_Y_RST;
      axis_r[2]     <= cfe_pkg::AXIS_Z_RST;
      radius_r      <= cfe_pkg::RADIUS_RST;
      full_length_r <= cfe_pkg::LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfe_pkg::cfg_idx_t'(cfg_index))
        cfe_pkg::REG_AXIS_X:      axis_r[0] <= cfg_data[cfe_pkg::AXIS_W-1:0];
        cfe_pkg::REG_AXIS_Y:      axis_r[1] <= cfg_data[cfe_pkg::AXIS_W-1:0];
        cfe_pkg::REG_AXIS_Z:      axis_r[2] <= cfg_data[cfe_pkg::AXIS_W-1:0];
        cfe_pkg::REG_RADIUS:      radius_r <= cfg_data[cfe_pkg::RADIUS_W-1:0];
        cfe_pkg::REG_FULL_LENGTH: full_length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage valid bits and load enables.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic adv1, adv2, adv3, adv4, adv5, adv6, adv_out;
  logic rv_r [0:NSQ-1];
  logic radv [0:NSQ-1];
  logic out_valid_r;

  assign adv_out = !out_valid_r || !out_stall;
  assign adv6 = !v6_r || radv[0];
  assign adv5 = !v5_r || adv6;
  assign adv4 = !v4_r || adv5;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_stall = !adv1;

  // Stage 1: point times axis, per component.
  logic signed [cfe_pkg::POINT_W-1:0] p1_r [0:2];
  logic signed [cfe_pkg::PROD_W-1:0]  prod1_r [0:2];

  always_ff @(posedge clk) begin
    if (adv1) begin
      p1_r[0]    <= in_point_x;
      p1_r[1]    <= in_point_y;
      p1_r[2]    <= in_point_z;
      prod1_r[0] <= in_point_x * axis_r[0];
      prod1_r[1] <= in_point_y * axis_r[1];
      prod1_r[2] <= in_point_z * axis_r[2];
    end
  end

  // Stage 2: dot product and floor shift to the projection d.
  logic signed [cfe_pkg::POINT_W-1:0] p2_r [0:2];
  logic signed [cfe_pkg::PROJ_W-1:0]  d2_r;
  logic signed [cfe_pkg::DOT_W-1:0]   dot;
  logic signed [cfe_pkg::PROJ_W-1:0]  d2_nxt;

  always_comb begin
    dot = cfe_pkg::DOT_W'(prod1_r[0]) + cfe_pkg::DOT_W'(prod1_r[1])
        + cfe_pkg::DOT_W'(prod1_r[2]);
    // Dropping the low bits of a two's complement value floors toward minus infinity.
    d2_nxt = dot[cfe_pkg::DOT_W-1:cfe_pkg::AXIS_FRAC];
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      p2_r <= p1_r;
      d2_r <= d2_nxt;
    end
  end

  // Stage 3: projection times axis, per component.
  logic signed [cfe_pkg::POINT_W-1:0] p3_r [0:2];
  logic signed [cfe_pkg::PROJ_W-1:0]  d3_r;
  logic signed [cfe_pkg::PROJ2_W-1:0] prod3_r [0:2];

  always_ff @(posedge clk) begin
    if (adv3) begin
      p3_r       <= p2_r;
      d3_r       <= d2_r;
      prod3_r[0] <= d2_r * axis_r[0];
      prod3_r[1] <= d2_r * axis_r[1];
      prod3_r[2] <= d2_r * axis_r[2];
    end
  end

  // Stage 4: perpendicular vector and the end-cap test.
  logic signed [cfe_pkg::PERP_W-1:0] q4_r [0:2];
  logic signed [cfe_pkg::PERP_W-1:0] q4_nxt [0:2];
  logic                              cap4_r;
  logic                              cap4_nxt;
  logic [cfe_pkg::PROJ_W-1:0]        d_abs;
  logic [cfe_pkg::PROJ_W:0]          d_twice;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q4_nxt[i] = cfe_pkg::PERP_W'(p3_r[i])
                - cfe_pkg::PERP_W'($signed(prod3_r[i][cfe_pkg::PROJ2_W-1:cfe_pkg::AXIS_FRAC]));
    end
    d_abs = d3_r[cfe_pkg::PROJ_W-1] ? cfe_pkg::PROJ_W'(-d3_r) : cfe_pkg::PROJ_W'(d3_r);
    d_twice = {d_abs, 1'b0};
    cap4_nxt = !full_length_r[cfe_pkg::LEN_W-1]
            && (d_twice > (cfe_pkg::PROJ_W+1)'(full_length_r[cfe_pkg::LEN_W-2:0]));
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      q4_r   <= q4_nxt;
      cap4_r <= cap4_nxt;
    end
  end

  // Stage 5: squares.
  logic [cfe_pkg::SQ_W-1:0] sq5_r [0:2];
  logic                     cap5_r;

  always_ff @(posedge clk) begin
    if (adv5) begin
      for (int i = 0; i < 3; i++) begin
        sq5_r[i] <= cfe_pkg::SQ_W'(q4_r[i] * q4_r[i]);
      end
      cap5_r <= cap4_r;
    end
  end

  // Stage 6: squared length, Q28.16.
  logic [cfe_pkg::SQ_W-1:0] sum6_r;
  logic                     cap6_r;

  always_ff @(posedge clk) begin
    if (adv6) begin
      sum6_r <= sq5_r[0] + sq5_r[1] + sq5_r[2];
      cap6_r <= cap5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) v5_r <= v4_r;
      if (adv6) v6_r <= v5_r;
    end
  end

  // Square root: one result bit per stage, restoring method, two radicand bits a stage.
  logic [cfe_pkg::SQ_W-1:0]   rad_r  [0:NSQ-1];
  logic [cfe_pkg::REM_W-1:0]  rem_r  [0:NSQ-1];
  logic [cfe_pkg::ROOT_W-1:0] root_r [0:NSQ-1];
  logic                       rcap_r [0:NSQ-1];

  genvar k;
  generate
    for (k = 0; k < NSQ; k++) begin : g_sqrt
      logic [cfe_pkg::SQ_W-1:0]   rad_in;
      logic [cfe_pkg::REM_W-1:0]  rem_in;
      logic [cfe_pkg::ROOT_W-1:0] root_in;
      logic                       cap_in;
      logic                       v_in;
      logic [cfe_pkg::REM_W-1:0]  rem_ext;
      logic [cfe_pkg::REM_W-1:0]  trial;
      logic                       take;

      if (k == 0) begin : g_first
        assign rad_in  = sum6_r;
        assign rem_in  = '0;
        assign root_in = '0;
        assign cap_in  = cap6_r;
        assign v_in    = v6_r;
      end else begin : g_next
        assign rad_in  = rad_r[k-1];
        assign rem_in  = rem_r[k-1];
        assign root_in = root_r[k-1];
        assign cap_in  = rcap_r[k-1];
        assign v_in    = rv_r[k-1];
      end

      if (k == NSQ - 1) begin : g_last
        assign radv[k] = !rv_r[k] || adv_out;
      end else begin : g_mid
        assign radv[k] = !rv_r[k] || radv[k+1];
      end

      // The remainder never exceeds twice the partial root, so its top bits are zero here.
      assign rem_ext = {rem_in[cfe_pkg::REM_W-3:0], rad_in[cfe_pkg::SQ_W-1 -: 2]};
      assign trial   = {root_in, 2'b01};
      assign take    = rem_ext >= trial;

      always_ff @(posedge clk) begin
        if (radv[k]) begin
          rad_r[k]  <= {rad_in[cfe_pkg::SQ_W-3:0], 2'b00};
          rem_r[k]  <= take ? (rem_ext - trial) : rem_ext;
          root_r[k] <= {root_in[cfe_pkg::ROOT_W-2:0], take};
          rcap_r[k] <= cap_in;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          rv_r[k] <= 1'b0;
        end else if (radv[k]) begin
          rv_r[k] <= v_in;
        end
      end
    end
  endgenerate

  // Output stage: radius minus length, saturated, or the cap value.
  logic signed [cfe_pkg::FIELD_W-1:0] field_r;
  logic signed [cfe_pkg::FIELD_W-1:0] field_nxt;
  logic signed [cfe_pkg::FWIDE_W-1:0] fwide;

  always_comb begin
    fwide = $signed(cfe_pkg::FWIDE_W'(radius_r)) - $signed(cfe_pkg::FWIDE_W'(root_r[NSQ-1]));
    if (rcap_r[NSQ-1]) begin
      field_nxt = cfe_pkg::CAP_VALUE;
    end else if (fwide < cfe_pkg::FWIDE_W'(cfe_pkg::FIELD_MIN)) begin
      field_nxt = cfe_pkg::FIELD_MIN;
    end else begin
      field_nxt = fwide[cfe_pkg::FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      field_r <= field_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= rv_r[NSQ-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_field_value = field_r;

endmodule

/* hdl/cfe_checker.sv */
// Port-level checker for cylinder_field_eval, attached to it by the bind below.
// Depends on cfe_pkg for the field width.

module cfe_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [cfe_pkg::FIELD_W-1:0] out_field_value,
  input logic                               cfg_valid,
  input logic                               cfg_ready
);

  // A result held back by the receiver stays in place and unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_field_value))
    else $error("stalled result changed or vanished");

  // Reset empties the pipeline.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present right after reset");

  // The input side only stalls when a finished result is itself being held back.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the pipeline could move");

  // Register writes are never refused.
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration transfer refused");

endmodule

bind cylinder_field_eval cfe_checker u_cfe_checker (.*);

/* tb/cylinder_field_eval_checker.sv */
// Port checker for cylinder_field_eval: mirrors the register writes it sees,
// predicts the field value of every accepted point and compares results in order.
// Depends on cfe_pkg for widths, register codes and reset values.

module cylinder_field_eval_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [cfe_pkg::POINT_W-1:0]  in_point_x,
  input  logic signed [cfe_pkg::POINT_W-1:0]  in_point_y,
  input  logic signed [cfe_pkg::POINT_W-1:0]  in_point_z,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [cfe_pkg::FIELD_W-1:0]  out_field_value,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [cfe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cfe_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                  fail_count,
  output int                                  pending
);

  typedef struct packed {
    logic signed [cfe_pkg::POINT_W-1:0] x;
    logic signed [cfe_pkg::POINT_W-1:0] y;
    logic signed [cfe_pkg::POINT_W-1:0] z;
    logic signed [cfe_pkg::FIELD_W-1:0] value;
  } field_want_t;

  logic signed [cfe_pkg::AXIS_W-1:0] axis_reg [3];
  logic [cfe_pkg::RADIUS_W-1:0]      radius_reg;
  logic signed [cfe_pkg::LEN_W-1:0]  length_reg;
  field_want_t                       field_queue [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned rest;
    longint unsigned res;
    longint unsigned probe;
    rest = v;
    res = 0;
    probe = 64'd1 << 62;
    while (probe > rest)
      probe >>= 2;
    while (probe != 0) begin
      if (rest >= res + probe) begin
        rest -= res + probe;
        res = (res >> 1) + probe;
      end else begin
        res >>= 1;
      end
      probe >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [cfe_pkg::FIELD_W-1:0] eval_field(
    input logic signed [cfe_pkg::POINT_W-1:0] px,
    input logic signed [cfe_pkg::POINT_W-1:0] py,
    input logic signed [cfe_pkg::POINT_W-1:0] pz
  );
    longint pt [3];
    longint dot;
    longint proj;
    longint perp;
    longint unsigned sq_len;
    longint len;
    longint f;
    longint abs_proj;
    pt[0] = px;
    pt[1] = py;
    pt[2] = pz;
    dot = 0;
    for (int i = 0; i < 3; i++)
      dot += pt[i] * longint'(axis_reg[i]);
    // Arithmetic shifts of signed values floor toward minus infinity.
    proj = dot >>> cfe_pkg::AXIS_FRAC;
    sq_len = 0;
    for (int i = 0; i < 3; i++) begin
      perp = pt[i] - ((proj * longint'(axis_reg[i])) >>> cfe_pkg::AXIS_FRAC);
      sq_len += longint'(perp * perp);
    end
    len = longint'(root_floor(sq_len));
    f = longint'(radius_reg) - len;
    if (f < longint'(cfe_pkg::FIELD_MIN))
      f = cfe_pkg::FIELD_MIN;
    if (length_reg >= 0) begin
      abs_proj = proj < 0 ? -proj : proj;
      if (2 * abs_proj > longint'(length_reg))
        f = cfe_pkg::CAP_VALUE;
    end
    return f[cfe_pkg::FIELD_W-1:0];
  endfunction

  always @(posedge clk) begin : monitor
    field_want_t want;
    if (!rst_n) begin
      axis_reg[0] <= cfe_pkg::AXIS_X_RST;
      axis_reg[1] <= cfe_pkg::AXIS_Y_RST;
      axis_reg[2] <= cfe_pkg::AXIS_Z_RST;
      radius_reg <= cfe_pkg::RADIUS_RST;
      length_reg <= cfe_pkg::LEN_RST;
      field_queue.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cfe_pkg::REG_AXIS_X:      axis_reg[0] <= cfg_data[cfe_pkg::AXIS_W-1:0];
          cfe_pkg::REG_AXIS_Y:      axis_reg[1] <= cfg_data[cfe_pkg::AXIS_W-1:0];
          cfe_pkg::REG_AXIS_Z:      axis_reg[2] <= cfg_data[cfe_pkg::AXIS_W-1:0];
          cfe_pkg::REG_RADIUS:      radius_reg <= cfg_data[cfe_pkg::RADIUS_W-1:0];
          cfe_pkg::REG_FULL_LENGTH: length_reg <= cfg_data[cfe_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        want.x = in_point_x;
        want.y = in_point_y;
        want.z = in_point_z;
        want.value = eval_field(in_point_x, in_point_y, in_point_z);
        field_queue.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (field_queue.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", out_field_value));
        end else begin
          want = field_queue.pop_front();
          if (out_field_value !== want.value)
            report_mismatch($sformatf("point (%0d, %0d, %0d): field %0d, expected %0d",
                                      want.x, want.y, want.z, out_field_value, want.value));
        end
      end
      pending <= field_queue.size();
    end
  end

endmodule

/* tb/cylinder_field_eval_test.sv */
// Testbench top for cylinder_field_eval: clock, reset, point and register stimulus,
// random output stalls and the verdict. Depends on cfe_pkg and the checker module.

module cylinder_field_eval_test;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [cfe_pkg::POINT_W-1:0] in_point_x;
  logic signed [cfe_pkg::POINT_W-1:0] in_point_y;
  logic signed [cfe_pkg::POINT_W-1:0] in_point_z;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [cfe_pkg::FIELD_W-1:0] out_field_value;
  logic cfg_valid;
  logic cfg_ready;
  logic [cfe_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cfe_pkg::CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int stall_hold = 0;
  bit quiet_phase;

  always #4 clk = ~clk;

  cylinder_field_eval dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_point_x(in_point_x),
    .in_point_y(in_point_y),
    .in_point_z(in_point_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_field_value(out_field_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  cylinder_field_eval_checker checker_i (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_point_x(in_point_x),
    .in_point_y(in_point_y),
    .in_point_z(in_point_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_field_value(out_field_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count),
    .pending(pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** cylinder_field_eval: FAILED **");
      $finish;
    end
  end

  // Result-side back-pressure: short stalls, occasional long ones, and
  // stretches where every result is taken at once.
  always @(posedge clk) begin : stall_gen
    int r;
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall <= 1'b0;
        stall_hold <= $urandom_range(0, 6);
      end else if (r < 85) begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(0, 3);
      end else if (r < 95) begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(10, 40);
      end else begin
        out_stall <= 1'b0;
        stall_hold <= $urandom_range(60, 200);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet_phase)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 40);
  endfunction

  function automatic logic [cfe_pkg::POINT_W-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5)
      return cfe_pkg::POINT_W'($urandom);
    else if (r < 9)
      return cfe_pkg::POINT_W'($urandom_range(0, 4095)) - 16'd2048;
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'hffff;
    endcase
  endfunction

  // Holds valid across back-to-back transfers; it drops only for a gap.
  task automatic send_point(input logic [cfe_pkg::POINT_W-1:0] x, y, z);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // The extra edge lets the count include a transfer made at the current edge.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cfe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cfe_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(input logic [cfe_pkg::CFG_DATA_W-1:0] ax, ay, az, rad, len);
    write_reg(cfe_pkg::REG_AXIS_X, ax);
    write_reg(cfe_pkg::REG_AXIS_Y, ay);
    write_reg(cfe_pkg::REG_AXIS_Z, az);
    write_reg(cfe_pkg::REG_RADIUS, rad);
    write_reg(cfe_pkg::REG_FULL_LENGTH, len);
    // Writes to indexes past the register list must leave everything unchanged.
    if ($urandom_range(0, 1))
      write_reg(cfe_pkg::CFG_IDX_W'($urandom_range(cfe_pkg::REG_FULL_LENGTH + 1,
                                                   (1 << cfe_pkg::CFG_IDX_W) - 1)),
                cfe_pkg::CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic random_config();
    logic [cfe_pkg::AXIS_W-1:0] ax [3];
    logic [cfe_pkg::RADIUS_W-1:0] rad;
    logic [cfe_pkg::CFG_DATA_W-1:0] len;
    int k;
    case ($urandom_range(0, 3))
      0: begin
        ax = '{16'd0, 16'd0, 16'd0};
        k = $urandom_range(0, 2);
        ax[k] = $urandom_range(0, 1) ? 16'd16384 : -16'd16384;
      end
      1: for (int i = 0; i < 3; i++)
           ax[i] = cfe_pkg::AXIS_W'($urandom_range(0, 32768)) - 16'd16384;
      2: for (int i = 0; i < 3; i++) ax[i] = cfe_pkg::AXIS_W'($urandom);
      default: for (int i = 0; i < 3; i++) ax[i] = $urandom_range(0, 1) ? 16'd9459 : -16'd9459;
    endcase
    case ($urandom_range(0, 3))
      0: rad = 15'd0;
      1: rad = 15'h7fff;
      2: rad = cfe_pkg::RADIUS_W'($urandom_range(0, 4096));
      default: rad = cfe_pkg::RADIUS_W'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: len = 17'h1ffff;
      1: len = cfe_pkg::CFG_DATA_W'($urandom_range(0, 65535));
      2: len = cfe_pkg::CFG_DATA_W'($urandom_range(0, 2048));
      default: len = {1'b1, 16'($urandom)};
    endcase
    set_config({1'($urandom), ax[0]}, {1'($urandom), ax[1]}, {1'($urandom), ax[2]},
               {2'($urandom), rad}, len);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_point_x <= '0;
    in_point_y <= '0;
    in_point_z <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= cfe_pkg::REG_AXIS_X;
    cfg_data <= '0;
    quiet_phase = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: unit z axis, radius 1.0, unbounded.
    send_point(16'd0, 16'd0, 16'd0);
    send_point(16'h7fff, 16'h7fff, 16'h7fff);
    send_point(16'h8000, 16'h8000, 16'h8000);
    send_point(16'h8000, 16'h7fff, 16'd0);
    send_point(16'd256, 16'd0, 16'd1000);
    send_point(16'd0, -16'd256, 16'h8000);
    drain();

    // Caps at |d| = 1.0; exactly on a cap still counts as inside.
    set_config(17'd16384, 17'd0, 17'd0, 17'd32767, 17'd512);
    send_point(16'd256, 16'd5, 16'd0);
    send_point(16'd257, 16'd0, 16'd0);
    send_point(-16'd256, 16'd0, -16'd7);
    send_point(-16'd257, 16'd0, 16'd0);
    drain();

    // Zero length: only points with zero projection are inside.
    set_config(17'd0, 17'd0, 17'd16384, 17'd256, 17'd0);
    send_point(16'd100, 16'd0, 16'd0);
    send_point(16'd0, 16'd0, 16'd1);
    send_point(16'd0, 16'd0, -16'd1);
    drain();

    // Oversized axis drives the field below range, where it saturates.
    set_config(17'h08000, 17'h18000, 17'h08000, 17'd0, 17'h1ffff);
    send_point(16'h7fff, 16'h7fff, 16'h7fff);
    send_point(16'h8000, 16'h8000, 16'h8000);
    drain();

    // Largest positive axis with the largest length, then the most negative length.
    set_config(17'h17fff, 17'h07fff, 17'h17fff, 17'h1ffff, 17'd65535);
    send_point(16'h7fff, 16'h8000, 16'h7fff);
    drain();
    set_config(17'h1c000, 17'd0, 17'd0, 17'd300, 17'h10000);
    send_point(16'h7fff, 16'd12, 16'h8000);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      random_config();
      quiet_phase = ($urandom_range(0, 3) == 0);
      repeat (50) send_point(pick_coord(), pick_coord(), pick_coord());
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("** cylinder_field_eval: PASSED **");
    else
      $display("** cylinder_field_eval: FAILED **");
    $finish;
  end

endmodule
